@@ rtl/bpa_pkg.sv @@
// Shared types, codes and constants of the buddy page allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

   // Default sizing
   localparam int PAGE_COUNT_DEF  = 4096;
   localparam int ORDER_COUNT_DEF = 11;

   // Fixed field widths
   localparam int ORD_W     = 4;
   localparam int PAGE_W    = 12;
   localparam int CFG_W     = 13;
   localparam int CSR_IDX_W = 1;

   // Configuration register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_END   = 1'b1;
   localparam logic [CFG_W-1:0]     FIRST_RST = 13'd1;
   localparam logic [CFG_W-1:0]     END_RST   = 13'd4096;

   // Request types
   localparam logic [1:0] REQ_ALLOC = 2'd0;
   localparam logic [1:0] REQ_FREE  = 2'd1;
   localparam logic [1:0] REQ_POP   = 2'd2;
   localparam logic [1:0] REQ_NONE  = 2'd3;

   // Response status codes
   localparam logic [1:0] ST_OK           = 2'd0;
   localparam logic [1:0] ST_BAD_ORDER    = 2'd1;
   localparam logic [1:0] ST_NO_BLOCK     = 2'd2;
   localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

   // Datapath operations
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NOP     = 5'd0;
   localparam logic [OP_W-1:0] OP_CLR     = 5'd1;
   localparam logic [OP_W-1:0] OP_LOAD    = 5'd2;
   localparam logic [OP_W-1:0] OP_BADORD  = 5'd3;
   localparam logic [OP_W-1:0] OP_FIND    = 5'd4;
   localparam logic [OP_W-1:0] OP_ULRD    = 5'd5;
   localparam logic [OP_W-1:0] OP_ULWR    = 5'd6;
   localparam logic [OP_W-1:0] OP_SPLIT   = 5'd7;
   localparam logic [OP_W-1:0] OP_PUSH1   = 5'd8;
   localparam logic [OP_W-1:0] OP_PUSH2   = 5'd9;
   localparam logic [OP_W-1:0] OP_CHKINIT = 5'd10;
   localparam logic [OP_W-1:0] OP_SCANRD  = 5'd11;
   localparam logic [OP_W-1:0] OP_SCANCK  = 5'd12;
   localparam logic [OP_W-1:0] OP_PSET    = 5'd13;
   localparam logic [OP_W-1:0] OP_MRGRD   = 5'd14;
   localparam logic [OP_W-1:0] OP_MRGCK   = 5'd15;
   localparam logic [OP_W-1:0] OP_PINIT   = 5'd16;
   localparam logic [OP_W-1:0] OP_PTZ     = 5'd17;
   localparam logic [OP_W-1:0] OP_PDEC    = 5'd18;
   localparam logic [OP_W-1:0] OP_PNEXT   = 5'd19;

   typedef struct packed {
      logic [1:0]       req_type;
      logic [ORD_W-1:0] order;
      logic [PAGE_W-1:0] page_number;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]        status;
      logic [PAGE_W-1:0] page_number_out;
   } rsp_payload_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic       order_bad;
      logic       found;
      logic       range_bad;
      logic       scan_hit;
      logic       scan_last;
      logic       at_top;
      logic       merge_ok;
      logic       split_more;
      logic       pop_more;
      logic       dec_more;
      logic       clr_last;
   } dp_sts_type;

endpackage
`default_nettype wire

@@ rtl/bpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/bpa_ctrl.sv @@
// Sequencer for the buddy page allocator: walks each request through datapath operations.
`timescale 1ns / 1ps
`default_nettype none
module bpa_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_ready,
   output      logic                rsp_valid,
   input  wire logic                rsp_ready,
   output      bpa_pkg::dp_cmd_type cmd,
   input  wire bpa_pkg::dp_sts_type sts
);

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_IDLE  = 5'd1;
   localparam logic [4:0] S_DISP  = 5'd2;
   localparam logic [4:0] S_AFIND = 5'd3;
   localparam logic [4:0] S_ARD   = 5'd4;
   localparam logic [4:0] S_AUL   = 5'd5;
   localparam logic [4:0] S_ASPL  = 5'd6;
   localparam logic [4:0] S_PUSH1 = 5'd7;
   localparam logic [4:0] S_PUSH2 = 5'd8;
   localparam logic [4:0] S_FCHK  = 5'd9;
   localparam logic [4:0] S_SRD   = 5'd10;
   localparam logic [4:0] S_SCK   = 5'd11;
   localparam logic [4:0] S_MRD   = 5'd12;
   localparam logic [4:0] S_MCK   = 5'd13;
   localparam logic [4:0] S_PINIT = 5'd14;
   localparam logic [4:0] S_PTOP  = 5'd15;
   localparam logic [4:0] S_PDEC  = 5'd16;
   localparam logic [4:0] S_PNEXT = 5'd17;
   localparam logic [4:0] S_RESP  = 5'd18;

   logic [4:0] state_ff;
   logic [4:0] state_in;
   logic [4:0] fail_state;
   logic       is_pop;

   // A rejected block ends a free request but only skips ahead in populate
   assign is_pop     = (sts.req_type == bpa_pkg::REQ_POP);
   assign fail_state = is_pop ? S_PNEXT : S_RESP;

   // Next state and operation
   always_comb begin
      state_in  = state_ff;
      cmd.op    = bpa_pkg::OP_NOP;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         S_CLR: begin
            cmd.op = bpa_pkg::OP_CLR;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = bpa_pkg::OP_LOAD;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (sts.req_type)
               bpa_pkg::REQ_ALLOC: state_in = S_AFIND;
               bpa_pkg::REQ_FREE: begin
                  if (sts.order_bad) begin
                     cmd.op   = bpa_pkg::OP_BADORD;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_FCHK;
                  end
               end
               bpa_pkg::REQ_POP: state_in = S_PINIT;
               default: state_in = S_RESP;
            endcase
         end
         S_AFIND: begin
            cmd.op   = bpa_pkg::OP_FIND;
            state_in = (sts.order_bad || !sts.found) ? S_RESP : S_ARD;
         end
         S_ARD: begin
            cmd.op   = bpa_pkg::OP_ULRD;
            state_in = S_AUL;
         end
         S_AUL: begin
            cmd.op   = bpa_pkg::OP_ULWR;
            state_in = S_ASPL;
         end
         S_ASPL: begin
            if (sts.split_more) begin
               cmd.op   = bpa_pkg::OP_SPLIT;
               state_in = S_PUSH1;
            end else begin
               state_in = S_RESP;
            end
         end
         S_PUSH1: begin
            cmd.op   = bpa_pkg::OP_PUSH1;
            state_in = S_PUSH2;
         end
         S_PUSH2: begin
            cmd.op = bpa_pkg::OP_PUSH2;
            case (sts.req_type)
               bpa_pkg::REQ_ALLOC: state_in = S_ASPL;
               bpa_pkg::REQ_FREE:  state_in = S_RESP;
               default:            state_in = S_PNEXT;
            endcase
         end
         S_FCHK: begin
            cmd.op   = bpa_pkg::OP_CHKINIT;
            state_in = sts.range_bad ? fail_state : S_SRD;
         end
         S_SRD: begin
            cmd.op   = bpa_pkg::OP_SCANRD;
            state_in = S_SCK;
         end
         S_SCK: begin
            cmd.op = bpa_pkg::OP_SCANCK;
            if (sts.scan_hit) begin
               state_in = fail_state;
            end else if (sts.scan_last) begin
               state_in = S_MRD;
            end else begin
               state_in = S_SRD;
            end
         end
         S_MRD: begin
            if (sts.at_top) begin
               cmd.op   = bpa_pkg::OP_PSET;
               state_in = S_PUSH1;
            end else begin
               cmd.op   = bpa_pkg::OP_MRGRD;
               state_in = S_MCK;
            end
         end
         S_MCK: begin
            cmd.op   = bpa_pkg::OP_MRGCK;
            state_in = sts.merge_ok ? S_MRD : S_PUSH1;
         end
         S_PINIT: begin
            cmd.op   = bpa_pkg::OP_PINIT;
            state_in = S_PTOP;
         end
         S_PTOP: begin
            if (sts.pop_more) begin
               cmd.op   = bpa_pkg::OP_PTZ;
               state_in = S_PDEC;
            end else begin
               state_in = S_RESP;
            end
         end
         S_PDEC: begin
            if (sts.dec_more) begin
               cmd.op = bpa_pkg::OP_PDEC;
            end else begin
               state_in = S_FCHK;
            end
         end
         S_PNEXT: begin
            cmd.op   = bpa_pkg::OP_PNEXT;
            state_in = S_PTOP;
         end
         S_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/bpa_dpath.sv @@
// Datapath of the buddy page allocator: list heads, page stores, working registers.
`timescale 1ns / 1ps
`default_nettype none
module bpa_dpath #(
   parameter int PAGE_COUNT  = bpa_pkg::PAGE_COUNT_DEF,
   parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire bpa_pkg::req_payload_type           req_payload,
   input  wire logic                               csr_we,
   input  wire logic [bpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [bpa_pkg::CFG_W-1:0]          csr_wdata,
   input  wire bpa_pkg::dp_cmd_type                cmd,
   output      bpa_pkg::dp_sts_type                sts,
   output      bpa_pkg::rsp_payload_type           rsp_payload
);

   localparam int PW  = $clog2(PAGE_COUNT);
   localparam int AW  = PW + 1;
   localparam int OW  = bpa_pkg::ORD_W;
   localparam int OIW = $clog2(ORDER_COUNT);
   localparam int SW  = (bpa_pkg::CFG_W > AW) ? bpa_pkg::CFG_W : AW;
   localparam int XW  = SW + ORDER_COUNT;
   localparam int IW  = OW + 1;
   localparam logic [AW-1:0] NONE     = AW'(PAGE_COUNT);
   localparam logic [XW-1:0] PAGES_X  = XW'(PAGE_COUNT);
   localparam logic [OW-1:0] TOP_ORD  = OW'(ORDER_COUNT - 1);
   localparam logic [PW-1:0] LAST_PG  = PW'(PAGE_COUNT - 1);

   // Working registers
   logic [1:0]          rtype_ff;
   logic [OW-1:0]       rord_ff;
   logic [PW-1:0]       pg_ff;
   logic [OW-1:0]       ord_ff;
   logic [PW-1:0]       ppg_ff;
   logic [AW-1:0]       old_ff;
   logic [1:0]          st_ff;
   logic [ORDER_COUNT-1:0] cnt_ff;
   logic [OW-1:0]       sord_ff;
   logic [SW-1:0]       start_ff;
   logic [SW-1:0]       stop_ff;
   logic [PW-1:0]       clr_ff;
   logic [bpa_pkg::CFG_W-1:0] first_ff;
   logic [bpa_pkg::CFG_W-1:0] end_ff;
   logic [AW-1:0]       head_ff [ORDER_COUNT];

   // Memory ports
   logic          info_we;
   logic [PW-1:0] info_wa;
   logic [IW-1:0] info_wd;
   logic [PW-1:0] info_ra;
   logic [IW-1:0] info_rd;
   logic          nxt_we;
   logic [PW-1:0] nxt_wa;
   logic [AW-1:0] nxt_wd;
   logic [AW-1:0] nxt_rd;
   logic          prv_we;
   logic [PW-1:0] prv_wa;
   logic [AW-1:0] prv_wd;
   logic [AW-1:0] prv_rd;
   logic [PW-1:0] link_ra;

   // Derived values
   logic [OIW-1:0] ord_idx;
   logic [XW-1:0]  size_x;
   logic [XW-1:0]  half_x;
   logic [XW-1:0]  bud_x;
   logic [PW-1:0]  bud;
   logic [PW-1:0]  scan_addr;
   logic           found;
   logic [OIW-1:0] fidx;
   logic [OW-1:0]  tz;
   logic           do_ul;
   logic [PW-1:0]  ul_tgt;

   assign ord_idx   = ord_ff[OIW-1:0];
   assign size_x    = XW'(1) << ord_ff;
   assign half_x    = XW'(1) << (ord_ff - OW'(1));
   assign bud_x     = XW'(pg_ff) ^ size_x;
   assign bud       = bud_x[PW-1:0];
   assign scan_addr = pg_ff + PW'(cnt_ff);

   // Find the smallest non-empty list at or above the requested order
   always_comb begin
      found = 1'b0;
      fidx  = '0;
      for (int k = ORDER_COUNT - 1; k >= 0; k--) begin
         if (OW'(k) >= rord_ff && head_ff[k] != NONE) begin
            found = 1'b1;
            fidx  = OIW'(k);
         end
      end
   end

   // Alignment of the populate start, capped at the top order
   always_comb begin
      tz = TOP_ORD;
      for (int k = ORDER_COUNT - 2; k >= 0; k--) begin
         if (start_ff[k]) begin
            tz = OW'(k);
         end
      end
   end

   // Status toward the sequencer
   always_comb begin
      sts.req_type   = rtype_ff;
      sts.order_bad  = {1'b0, rord_ff} >= (OW + 1)'(ORDER_COUNT);
      sts.found      = found;
      sts.range_bad  = (XW'(pg_ff) + size_x) > PAGES_X;
      sts.scan_hit   = info_rd[OW];
      sts.scan_last  = XW'(cnt_ff) == (size_x - XW'(1));
      sts.at_top     = ord_ff == TOP_ORD;
      sts.merge_ok   = (bud_x < PAGES_X) && info_rd[OW] && (info_rd[OW-1:0] == ord_ff);
      sts.split_more = ord_ff > rord_ff;
      sts.pop_more   = start_ff < stop_ff;
      sts.dec_more   = (ord_ff != '0) && ((XW'(start_ff) + size_x) > XW'(stop_ff));
      sts.clr_last   = clr_ff == LAST_PG;
   end

   // Memory addressing and writes per operation
   always_comb begin
      info_we = 1'b0;
      info_wa = ppg_ff;
      info_wd = '0;
      info_ra = scan_addr;
      nxt_we  = 1'b0;
      nxt_wa  = ppg_ff;
      nxt_wd  = head_ff[ord_idx];
      prv_we  = 1'b0;
      prv_wa  = ppg_ff;
      prv_wd  = NONE;
      link_ra = pg_ff;
      do_ul   = 1'b0;
      ul_tgt  = pg_ff;
      case (cmd.op)
         bpa_pkg::OP_CLR: begin
            info_we = 1'b1;
            info_wa = clr_ff;
         end
         bpa_pkg::OP_ULWR: do_ul = 1'b1;
         bpa_pkg::OP_MRGRD: begin
            info_ra = bud;
            link_ra = bud;
         end
         bpa_pkg::OP_MRGCK: begin
            do_ul  = sts.merge_ok;
            ul_tgt = bud;
         end
         bpa_pkg::OP_PUSH1: begin
            info_we = 1'b1;
            info_wd = {1'b1, ord_ff};
            nxt_we  = 1'b1;
            prv_we  = 1'b1;
         end
         bpa_pkg::OP_PUSH2: begin
            prv_we = old_ff != NONE;
            prv_wa = old_ff[PW-1:0];
            prv_wd = AW'(ppg_ff);
         end
         default: ;
      endcase
      // Unlink: bridge neighbors and drop the head mark
      if (do_ul) begin
         info_we = 1'b1;
         info_wa = ul_tgt;
         info_wd = '0;
         nxt_we  = prv_rd != NONE;
         nxt_wa  = prv_rd[PW-1:0];
         nxt_wd  = nxt_rd;
         prv_we  = nxt_rd != NONE;
         prv_wa  = nxt_rd[PW-1:0];
         prv_wd  = prv_rd;
      end
   end

   // Control registers: list heads, clearing sweep, configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < ORDER_COUNT; k++) begin
            head_ff[k] <= NONE;
         end
         clr_ff   <= '0;
         first_ff <= bpa_pkg::FIRST_RST;
         end_ff   <= bpa_pkg::END_RST;
      end else begin
         if (cmd.op == bpa_pkg::OP_CLR) begin
            clr_ff <= clr_ff + PW'(1);
         end
         if (cmd.op == bpa_pkg::OP_PUSH1) begin
            head_ff[ord_idx] <= AW'(ppg_ff);
         end
         if (do_ul && prv_rd == NONE) begin
            head_ff[ord_idx] <= nxt_rd;
         end
         if (csr_we) begin
            case (csr_index)
               bpa_pkg::CSR_FIRST: first_ff <= csr_wdata;
               bpa_pkg::CSR_END:   end_ff   <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Working registers per operation
   always_ff @(posedge clock) begin
      case (cmd.op)
         bpa_pkg::OP_LOAD: begin
            rtype_ff <= req_payload.req_type;
            rord_ff  <= req_payload.order;
            pg_ff    <= PW'(req_payload.page_number);
            ord_ff   <= req_payload.order;
            st_ff    <= bpa_pkg::ST_OK;
         end
         bpa_pkg::OP_BADORD: st_ff <= bpa_pkg::ST_BAD_ORDER;
         bpa_pkg::OP_FIND: begin
            if (sts.order_bad) begin
               st_ff <= bpa_pkg::ST_BAD_ORDER;
            end else if (!found) begin
               st_ff <= bpa_pkg::ST_NO_BLOCK;
            end else begin
               pg_ff  <= head_ff[fidx][PW-1:0];
               ord_ff <= OW'(fidx);
            end
         end
         bpa_pkg::OP_SPLIT: begin
            ord_ff <= ord_ff - OW'(1);
            ppg_ff <= pg_ff + half_x[PW-1:0];
         end
         bpa_pkg::OP_PUSH1: old_ff <= head_ff[ord_idx];
         bpa_pkg::OP_CHKINIT: begin
            cnt_ff  <= '0;
            sord_ff <= ord_ff;
            if (sts.range_bad) begin
               st_ff <= bpa_pkg::ST_BAD_ORDER;
            end
         end
         bpa_pkg::OP_SCANCK: begin
            cnt_ff <= cnt_ff + ORDER_COUNT'(1);
            if (sts.scan_hit) begin
               st_ff <= bpa_pkg::ST_ALREADY_FREE;
            end
         end
         bpa_pkg::OP_PSET: ppg_ff <= pg_ff;
         bpa_pkg::OP_MRGCK: begin
            if (sts.merge_ok) begin
               pg_ff  <= pg_ff & bud;
               ord_ff <= ord_ff + OW'(1);
            end else begin
               ppg_ff <= pg_ff;
            end
         end
         bpa_pkg::OP_PINIT: begin
            start_ff <= SW'(first_ff);
            stop_ff  <= (SW'(end_ff) > SW'(PAGE_COUNT)) ? SW'(PAGE_COUNT) : SW'(end_ff);
         end
         bpa_pkg::OP_PTZ: begin
            pg_ff  <= start_ff[PW-1:0];
            ord_ff <= tz;
         end
         bpa_pkg::OP_PDEC: ord_ff <= ord_ff - OW'(1);
         bpa_pkg::OP_PNEXT: begin
            start_ff <= start_ff + SW'(XW'(1) << sord_ff);
         end
         default: ;
      endcase
   end

   // Response fields
   assign rsp_payload.status = st_ff;
   assign rsp_payload.page_number_out =
      (rtype_ff == bpa_pkg::REQ_ALLOC && st_ff == bpa_pkg::ST_OK) ?
      bpa_pkg::PAGE_W'(pg_ff) : '0;

   // Head flag and order per page
   bpa_ram #(.WIDTH(IW), .DEPTH(PAGE_COUNT)) u_info_ram (
      .clock   (clock),
      .wr_en   (info_we),
      .wr_addr (info_wa),
      .wr_data (info_wd),
      .rd_addr (info_ra),
      .rd_data (info_rd)
   );

   // Forward links
   bpa_ram #(.WIDTH(AW), .DEPTH(PAGE_COUNT)) u_nxt_ram (
      .clock   (clock),
      .wr_en   (nxt_we),
      .wr_addr (nxt_wa),
      .wr_data (nxt_wd),
      .rd_addr (link_ra),
      .rd_data (nxt_rd)
   );

   // Backward links
   bpa_ram #(.WIDTH(AW), .DEPTH(PAGE_COUNT)) u_prv_ram (
      .clock   (clock),
      .wr_en   (prv_we),
      .wr_addr (prv_wa),
      .wr_data (prv_wd),
      .rd_addr (link_ra),
      .rd_data (prv_rd)
   );

endmodule
`default_nettype wire

@@ rtl/buddy_page_allocator.sv @@
// Top level of the buddy page allocator: sequencer, datapath and checks.
//
//  Channel  Direction  Handshake            Payload
//  req      in         req_valid/req_ready  req_payload (req_type, order, page_number)
//  rsp      out        rsp_valid/rsp_ready  rsp_payload (status, page_number_out)
//  csr      in         csr_we               csr_index, csr_wdata
//
// One request at a time. Allocate finds a block and splits it down to the
// requested order; free scans the head flags of the block, then merges with
// free buddies until a buddy is not free or the top order is reached.
// Populate runs such a free for each aligned block of the configured range.
// The scan and merge walk go through the single read port of the page store.
// After reset a clearing pass over every page empties the head flags;
// no request is taken until it ends. A stalled response holds the block.
`timescale 1ns / 1ps
`default_nettype none
module buddy_page_allocator #(
   parameter int PAGE_COUNT  = bpa_pkg::PAGE_COUNT_DEF,
   parameter int ORDER_COUNT = bpa_pkg::ORDER_COUNT_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output      logic                          req_ready,
   input  wire bpa_pkg::req_payload_type      req_payload,
   output      logic                          rsp_valid,
   input  wire logic                          rsp_ready,
   output      bpa_pkg::rsp_payload_type      rsp_payload,
   input  wire logic                          csr_we,
   input  wire logic [bpa_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [bpa_pkg::CFG_W-1:0]     csr_wdata
);

   bpa_pkg::dp_cmd_type cmd;
   bpa_pkg::dp_sts_type sts;

   bpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   bpa_dpath #(.PAGE_COUNT(PAGE_COUNT), .ORDER_COUNT(ORDER_COUNT)) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_payload (rsp_payload)
   );

   // Never take a request while a response is pending
   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid))
      else $error("request taken while response pending");

   // A request never answers in the cycle after it is taken
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid)
      else $error("response too early");

   // Only a successful response carries a page
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != bpa_pkg::ST_OK) |->
      (rsp_payload.page_number_out == '0))
      else $error("page on failed response");

endmodule
`default_nettype wire
